FILE: hw/rtl/rational_fraction_alu_top_assert.svh
// Assertion macros for the rational fraction ALU
`ifndef RATIONAL_FRACTION_ALU_TOP_ASSERT_SVH
`define RATIONAL_FRACTION_ALU_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define RFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define RFA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/rfa_pkg.sv
// Package for the rational fraction ALU: types, codes and constants
`timescale 1ns / 1ps
`default_nettype none
package rfa_pkg;
  localparam int unsigned DEF_WIDTH = 32;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
    OP_DIV = 3'd3, OP_CMP = 3'd4, OP_RED = 3'd5,
    OP_UN6 = 3'd6, OP_UN7 = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0, CMP_LT = 2'd1, CMP_GT = 2'd2
  } cmp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_ARITH, ST_GCD_CHK, ST_MOD_RUN,
    ST_QN_RUN, ST_QD_RUN, ST_FIN, ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture input transaction
    logic mul1;      // first pair of products
    logic mul2;      // third product
    logic arith;     // form result for arithmetic/compare
    logic div_start; // start a divider pass
    logic div_step;  // one restoring step
    logic mod_end;   // divider done in gcd loop: rotate remainder
    logic qn_end;    // numerator quotient done
    logic qd_end;    // denominator quotient done
    logic gcd_zero;  // write zero gcd result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic y_zero;
    logic div_done;
    logic g_zero;
    op_t  op;
  } sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rfa_if.sv
// Valid/ready stream interfaces for the rational fraction ALU
`timescale 1ns / 1ps
`default_nettype none
interface rfa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [31:0] res_den;
  logic [1:0]  cmp_result;
  logic        overflow;
  logic        zero_gcd;
  modport source (output valid, res_num, res_den, cmp_result, overflow, zero_gcd,
                  input ready);
  modport sink (input valid, res_num, res_den, cmp_result, overflow, zero_gcd,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rational_fraction_alu_top.sv
// Top level of the rational fraction ALU
`timescale 1ns / 1ps
`default_nettype none
// Rational fraction ALU: one transaction at a time, one result per transaction.
// Add, subtract, multiply, divide and compare go through MUL1, MUL2 and ARITH to
// the result (products through one registered multiplier stage each).
// Reduce runs Euclid with a bit-serial divider; each modulo step is a zero test,
// WIDTH restoring steps and a rotate, and two more divider passes form the
// quotients; when numerator and denominator are both zero the divider is skipped
// and the zero-gcd result is given.
// The next transaction is taken in the cycle after the result has been delivered.
module rational_fraction_alu_top #(
  parameter int unsigned WIDTH = rfa_pkg::DEF_WIDTH
) (
  input wire logic clk,
  input wire logic rst_n,
  rfa_in_if.sink   in_ch,
  rfa_out_if.source out_ch
);
  import rfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rfa_dp #(.WIDTH(WIDTH)) u_dp (
    .clk         (clk),
    .in_req_type (in_ch.req_type),
    .in_a_num    (in_ch.a_num),
    .in_a_den    (in_ch.a_den),
    .in_b_num    (in_ch.b_num),
    .in_b_den    (in_ch.b_den),
    .cmd         (cmd),
    .sts         (sts),
    .res_num     (out_ch.res_num),
    .res_den     (out_ch.res_den),
    .cmp_result  (out_ch.cmp_result),
    .overflow    (out_ch.overflow),
    .zero_gcd    (out_ch.zero_gcd)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/rfa_ctrl.sv
// Controller state machine for the rational fraction ALU
`timescale 1ns / 1ps
`default_nettype none
module rfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rfa_pkg::sts_t sts,
  output rfa_pkg::cmd_t      cmd
);
  import rfa_pkg::*;
  `include "rational_fraction_alu_top_assert.svh"

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the operation
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        if (sts.op == OP_RED) begin
          state_nxt = ST_GCD_CHK;
        end else begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_ARITH;
      end
      ST_ARITH: begin
        cmd.arith = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_GCD_CHK: begin
        if (sts.y_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_MOD_RUN;
        end
      end
      ST_MOD_RUN: begin
        if (sts.div_done) begin
          cmd.mod_end = 1'b1;
          state_nxt   = ST_GCD_CHK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (sts.g_zero) begin
          cmd.gcd_zero = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_QN_RUN;
        end
      end
      ST_QN_RUN: begin
        if (sts.div_done) begin
          cmd.qn_end    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = ST_QD_RUN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_QD_RUN: begin
        if (sts.div_done) begin
          cmd.qd_end = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `RFA_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
  `RFA_ASSERT_NXT(a_load_goes_mul, in_valid && in_ready, state_r == ST_MUL1)
  `RFA_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

FILE: hw/rtl/rfa_dp.sv
// Datapath for the rational fraction ALU: multiplier, adder and serial divider
`timescale 1ns / 1ps
`default_nettype none
module rfa_dp #(
  parameter int unsigned WIDTH = rfa_pkg::DEF_WIDTH
) (
  input  wire logic          clk,
  input  wire logic [2:0]    in_req_type,
  input  wire logic [31:0]   in_a_num,
  input  wire logic [31:0]   in_a_den,
  input  wire logic [31:0]   in_b_num,
  input  wire logic [31:0]   in_b_den,
  input  wire rfa_pkg::cmd_t cmd,
  output rfa_pkg::sts_t      sts,
  output logic [31:0]        res_num,
  output logic [31:0]        res_den,
  output logic [1:0]         cmp_result,
  output logic               overflow,
  output logic               zero_gcd
);
  import rfa_pkg::*;

  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned CW = $clog2(WIDTH + 1);

  op_t                      op_r;
  logic signed [WIDTH-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [PW-1:0]     p_r, q_r, d_r;
  // Euclid registers and divider
  logic signed [WIDTH-1:0]  x_r, y_r;
  logic [WIDTH-1:0]         dvd_r, dvs_r, rem_r;
  logic [CW-1:0]            cnt_r;
  logic                     qneg_r, rneg_r;
  logic signed [WIDTH:0]    qn_r;
  // Result registers
  logic [31:0]              rn_r, rd_r;
  logic [1:0]               cmp_r;
  logic                     ovf_r, zg_r;

  logic signed [PW-1:0]     m0, m1;
  logic signed [PW:0]       sum;
  logic                     bad;
  logic [WIDTH:0]           trial;
  logic signed [WIDTH:0]    qsig;
  logic signed [WIDTH-1:0]  rsig;
  logic signed [WIDTH-1:0]  dsrc, vsrc;

  function automatic logic fits_p(input logic signed [PW:0] v);
    logic signed [PW:0] hi, lo;
    hi = (PW+1)'(2 ** (WIDTH - 1) - 1);
    lo = -(PW+1)'(2 ** (WIDTH - 1));
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic [31:0] wrap(input logic [PW:0] v);
    return 32'($signed(v[WIDTH-1:0]));
  endfunction

  // Pick products by operation
  always_comb begin
    case (op_r)
      OP_MUL:  begin m0 = an_r * bn_r; m1 = ad_r * bd_r; end
      OP_DIV:  begin m0 = an_r * bd_r; m1 = ad_r * bn_r; end
      default: begin m0 = an_r * bd_r; m1 = bn_r * ad_r; end
    endcase
  end

  // Sum or difference of cross products
  always_comb begin
    if (op_r == OP_SUB) begin
      sum = (PW+1)'(p_r) - (PW+1)'(q_r);
    end else begin
      sum = (PW+1)'(p_r) + (PW+1)'(q_r);
    end
    bad = !fits_p(sum) || !fits_p((PW+1)'(d_r));
  end

  // Restoring step on magnitudes
  assign trial = {rem_r, dvd_r[WIDTH-1]} - {1'b0, dvs_r};
  assign qsig  = qneg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  assign rsig  = rneg_r ? -$signed(rem_r) : $signed(rem_r);
  // While Euclid runs (y nonzero) divide x by y, afterwards divide by the gcd in x
  assign dsrc  = (y_r != '0) ? x_r : (cmd.qn_end ? ad_r : an_r);
  assign vsrc  = (y_r != '0) ? y_r : x_r;

  always_ff @(posedge clk) begin
    // Capture transaction
    if (cmd.load) begin
      op_r <= op_t'(in_req_type);
      an_r <= in_a_num[WIDTH-1:0];
      ad_r <= in_a_den[WIDTH-1:0];
      bn_r <= in_b_num[WIDTH-1:0];
      bd_r <= in_b_den[WIDTH-1:0];
      rn_r <= '0;
      rd_r <= '0;
      cmp_r <= CMP_EQ;
      ovf_r <= 1'b0;
      zg_r  <= 1'b0;
    end
    if (cmd.mul1) begin
      p_r <= m0;
      q_r <= m1;
      x_r <= an_r;
      y_r <= ad_r;
    end
    if (cmd.mul2) begin
      d_r <= ad_r * bd_r;
    end
    // Form arithmetic or compare result
    if (cmd.arith) begin
      case (op_r)
        OP_ADD, OP_SUB: begin
          rn_r  <= wrap(sum);
          rd_r  <= wrap((PW+1)'(d_r));
          ovf_r <= bad;
        end
        OP_MUL, OP_DIV: begin
          rn_r  <= wrap((PW+1)'(p_r));
          rd_r  <= wrap((PW+1)'(q_r));
          ovf_r <= !fits_p((PW+1)'(p_r)) || !fits_p((PW+1)'(q_r));
        end
        OP_CMP: begin
          if (p_r == q_r) begin
            cmp_r <= CMP_EQ;
          end else if ((p_r < q_r) != (d_r < 0)) begin
            cmp_r <= CMP_LT;
          end else begin
            cmp_r <= CMP_GT;
          end
        end
        default: begin
          rn_r <= '0;
        end
      endcase
    end
    // Start a divider pass: x % y in gcd loop, an/g, ad/g
    if (cmd.div_start) begin
      dvd_r  <= dsrc[WIDTH-1] ? WIDTH'(-dsrc) : WIDTH'(dsrc);
      dvs_r  <= vsrc[WIDTH-1] ? WIDTH'(-vsrc) : WIDTH'(vsrc);
      rem_r  <= '0;
      cnt_r  <= CW'(WIDTH);
      qneg_r <= dsrc[WIDTH-1] ^ vsrc[WIDTH-1];
      rneg_r <= dsrc[WIDTH-1];
    end else if (cmd.div_step) begin
      if (!trial[WIDTH]) begin
        rem_r <= trial[WIDTH-1:0];
        dvd_r <= {dvd_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[WIDTH-2:0], dvd_r[WIDTH-1]};
        dvd_r <= {dvd_r[WIDTH-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CW'(1);
    end
    // Rotate Euclid pair
    if (cmd.mod_end) begin
      x_r <= y_r;
      y_r <= rsig;
    end
    if (cmd.qn_end) begin
      qn_r <= qsig;
    end
    if (cmd.qd_end) begin
      rn_r  <= wrap((PW+1)'(qn_r));
      rd_r  <= wrap((PW+1)'(qsig));
      ovf_r <= (qn_r[WIDTH] != qn_r[WIDTH-1]) || (qsig[WIDTH] != qsig[WIDTH-1]);
    end
    if (cmd.gcd_zero) begin
      rn_r <= 32'(an_r);
      rd_r <= 32'(ad_r);
      zg_r <= 1'b1;
    end
  end

  assign sts.y_zero   = (y_r == '0);
  assign sts.g_zero   = (x_r == '0);
  assign sts.div_done = (cnt_r == '0);
  assign sts.op       = op_r;

  assign res_num    = rn_r;
  assign res_den    = rd_r;
  assign cmp_result = cmp_r;
  assign overflow   = ovf_r;
  assign zero_gcd   = zg_r;
endmodule
`default_nettype wire
